>>> hdl/rsi_pkg.sv
// Shared constants for the ray/sphere intersection unit.
// No dependencies.
package rsi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int RADIUS_W = 31;
  localparam int MARGIN_W = 16;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd655;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 1'b1;

  localparam logic OP_RAY     = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

endpackage

>>> hdl/ray_sphere_intersect_unit.sv
// Pipelined ray/sphere intersection test against a sphere at the origin.
// Depends on rsi_pkg.
//
// The unit accepts one ray word per cycle unless the output stalls, and returns one
// result word per ray, in order. SW = DW/2 is the width of the square root, where
// DW = max(2*FRAC_BITS + 66, 102). The square root is a digit-by-digit pipeline
// with one root bit per stage, and it sets the depth. The whole pipeline advances
// together whenever the output register is empty or being read, so a stall holds
// every stage in place. Radius and margin registers must only be written while no
// ray is in flight.
module ray_sphere_intersect_unit #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsi_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic signed [31:0]             in_origin_x,
  input  logic signed [31:0]             in_origin_y,
  input  logic signed [31:0]             in_origin_z,
  input  logic signed [17:0]             in_dir_x,
  input  logic signed [17:0]             in_dir_y,
  input  logic signed [17:0]             in_dir_z,
  input  logic [30:0]                    in_segment_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [30:0]                    out_distance
);
  import rsi_pkg::*;

  localparam int DW = (2*FRAC_BITS + 66 > 102) ? 2*FRAC_BITS + 66 : 102;
  localparam int SW = DW / 2;
  localparam int TW = SW + 8;

  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration registers.
  logic [RADIUS_W-1:0] radius_r;
  logic [MARGIN_W-1:0] margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      margin_r <= MARGIN_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        REG_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: single products.
  logic               v1_r;
  logic signed [49:0] px1_r, py1_r, pz1_r;
  logic [63:0]        sx1_r, sy1_r, sz1_r;
  logic [61:0]        rsq1_r;
  logic               op1_r;
  logic [30:0]        len1_r;

  logic signed [49:0] px_nxt, py_nxt, pz_nxt;
  logic signed [63:0] sx_nxt, sy_nxt, sz_nxt;
  logic [61:0]        rsq_nxt;

  always_comb begin
    px_nxt  = in_origin_x * in_dir_x;
    py_nxt  = in_origin_y * in_dir_y;
    pz_nxt  = in_origin_z * in_dir_z;
    sx_nxt  = in_origin_x * in_origin_x;
    sy_nxt  = in_origin_y * in_origin_y;
    sz_nxt  = in_origin_z * in_origin_z;
    rsq_nxt = radius_r * radius_r;
  end

  // Stage 2: b = origin . dir, and |origin|^2 modulo 2^64.
  logic               v2_r;
  logic signed [50:0] b2_r;
  logic [63:0]        osq2_r;
  logic [61:0]        rsq2_r;
  logic               op2_r;
  logic [30:0]        len2_r;

  // Stage 3: b^2 as three partial products.
  logic               v3_r;
  logic signed [50:0] b3_r;
  logic [63:0]        osq3_r;
  logic [61:0]        rsq3_r;
  logic               op3_r;
  logic [30:0]        len3_r;
  logic [49:0]        hh3_r, hl3_r, ll3_r;
  logic [50:0]        babs_full;
  logic [49:0]        babs;

  assign babs_full = b2_r[50] ? 51'(-b2_r) : 51'(b2_r);
  assign babs      = babs_full[49:0];

  // Stage 4: p = b^2 + r^2 * 2^2F and q = |o|^2 * 2^2F.
  logic               v4_r;
  logic signed [50:0] b4_r;
  logic               op4_r;
  logic [30:0]        len4_r;
  logic [DW-1:0]      p4_r, q4_r;

  // Stage 5: discriminant.
  logic               v5_r;
  logic signed [50:0] b5_r;
  logic               op5_r;
  logic [30:0]        len5_r;
  logic               ok5_r;
  logic [DW-1:0]      d5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= px_nxt;
      py1_r  <= py_nxt;
      pz1_r  <= pz_nxt;
      sx1_r  <= sx_nxt;
      sy1_r  <= sy_nxt;
      sz1_r  <= sz_nxt;
      rsq1_r <= rsq_nxt;
      op1_r  <= in_operation;
      len1_r <= in_segment_length;

      b2_r   <= 51'(px1_r) + 51'(py1_r) + 51'(pz1_r);
      osq2_r <= sx1_r + sy1_r + sz1_r;
      rsq2_r <= rsq1_r;
      op2_r  <= op1_r;
      len2_r <= len1_r;

      hh3_r  <= babs[49:25] * babs[49:25];
      hl3_r  <= babs[49:25] * babs[24:0];
      ll3_r  <= babs[24:0] * babs[24:0];
      b3_r   <= b2_r;
      osq3_r <= osq2_r;
      rsq3_r <= rsq2_r;
      op3_r  <= op2_r;
      len3_r <= len2_r;

      p4_r   <= (DW'(hh3_r) << 50) + (DW'(hl3_r) << 26) + DW'(ll3_r)
                + (DW'(rsq3_r) << (2*FRAC_BITS));
      q4_r   <= DW'(osq3_r) << (2*FRAC_BITS);
      b4_r   <= b3_r;
      op4_r  <= op3_r;
      len4_r <= len3_r;

      ok5_r  <= (p4_r >= q4_r);
      d5_r   <= p4_r - q4_r;
      b5_r   <= b4_r;
      op5_r  <= op4_r;
      len5_r <= len4_r;
    end
  end

  // Square root: one root bit per stage, most significant first.
  logic               vs_r   [SW];
  logic [DW-1:0]      rem_r  [SW];
  logic [SW-1:0]      root_r [SW];
  logic signed [50:0] bs_r   [SW];
  logic               ops_r  [SW];
  logic [30:0]        lens_r [SW];
  logic               oks_r  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int I = SW - 1 - k;
    logic               v_in;
    logic [DW-1:0]      rem_in;
    logic [SW-1:0]      root_in;
    logic signed [50:0] b_in;
    logic               op_in;
    logic [30:0]        len_in;
    logic               ok_in;
    logic [DW-1:0]      cand;
    logic               take;

    if (k == 0) begin : g_first
      assign v_in    = v5_r;
      assign rem_in  = d5_r;
      assign root_in = '0;
      assign b_in    = b5_r;
      assign op_in   = op5_r;
      assign len_in  = len5_r;
      assign ok_in   = ok5_r;
    end else begin : g_next
      assign v_in    = vs_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign b_in    = bs_r[k-1];
      assign op_in   = ops_r[k-1];
      assign len_in  = lens_r[k-1];
      assign ok_in   = oks_r[k-1];
    end

    // (r + 2^I)^2 - r^2 = r * 2^(I+1) + 2^(2I), where r has no bits below I+1.
    assign cand = (DW'(root_in) << (I + 1)) + (DW'(1) << (2*I));
    assign take = (rem_in >= cand);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k] <= 1'b0;
      end else if (en) begin
        vs_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? rem_in - cand : rem_in;
        root_r[k] <= take ? (root_in | (SW'(1) << I)) : root_in;
        bs_r[k]   <= b_in;
        ops_r[k]  <= op_in;
        lens_r[k] <= len_in;
        oks_r[k]  <= ok_in;
      end
    end
  end

  // Roots and segment window.
  logic                vt_r;
  logic signed [TW-1:0] t1_r, t2_r, lo_r, hi_r;
  logic                opt_r;
  logic                okt_r;
  logic signed [TW-1:0] bt, st;
  logic signed [32:0]   span;

  assign bt   = TW'(bs_r[SW-1]);
  assign st   = TW'({1'b0, root_r[SW-1]});
  assign span = $signed({2'b00, lens_r[SW-1]}) - $signed({17'd0, margin_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (en) begin
      vt_r <= vs_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= -bt - st;
      t2_r  <= -bt + st;
      lo_r  <= TW'({1'b0, margin_r}) << FRAC_BITS;
      hi_r  <= TW'(span) <<< FRAC_BITS;
      opt_r <= ops_r[SW-1];
      okt_r <= oks_r[SW-1];
    end
  end

  // Root selection and saturation.
  logic                 ok1, ok2, hit_nxt;
  logic signed [TW-1:0] t_sel;
  logic [TW-FRAC_BITS-1:0] dq;
  logic [30:0]          dist_nxt;

  always_comb begin
    if (opt_r == OP_SEGMENT) begin
      ok1 = (t1_r >= lo_r) && (t1_r <= hi_r);
      ok2 = (t2_r >= lo_r) && (t2_r <= hi_r);
    end else begin
      ok1 = !t1_r[TW-1];
      ok2 = !t2_r[TW-1];
    end
    hit_nxt = okt_r && (ok1 || ok2);
    t_sel   = ok1 ? t1_r : t2_r;
    dq      = t_sel[TW-1:FRAC_BITS];
    if (!hit_nxt) begin
      dist_nxt = '0;
    end else if (|dq[TW-FRAC_BITS-1:31]) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = dq[30:0];
    end
  end

  logic        out_hit_r;
  logic [30:0] out_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r      <= hit_nxt;
      out_distance_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;

  // A miss always reports zero distance.
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0)
    else $error("miss with nonzero distance");

  // While stalled, the first stage and the root stage keep their valid bits.
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(vt_r))
    else $error("pipeline moved during stall");

  // The pipeline comes out of reset empty.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid && !v1_r)
    else $error("pipeline not empty after reset");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the ray/sphere intersection unit.
// Depends on rsi_pkg and ray_sphere_intersect_unit; a scoreboard class predicts each result.
`timescale 1ns / 100ps

typedef struct {
  logic               op;
  logic signed [31:0] ox, oy, oz;
  logic signed [17:0] dx, dy, dz;
  logic [30:0]        len;
} ray_word_t;

typedef struct {
  logic        hit;
  logic [30:0] distance;
} hit_word_t;

class intersect_board;
  longint unsigned radius = rsi_pkg::RADIUS_RST;
  longint unsigned margin = rsi_pkg::MARGIN_RST;
  hit_word_t       pending[$];
  int              errors = 0;

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Half-coefficient quadratic with a = 1; roots are -b -/+ floor(sqrt(b*b - c)).
  function void note_ray(ray_word_t r);
    longint          b, t1, t2, lo, hi, t;
    longint unsigned babs, osq, rsq, root, cand, dq;
    logic [127:0]    p, q, disc, cw;
    hit_word_t       e;
    b = longint'(r.ox) * longint'(r.dx) + longint'(r.oy) * longint'(r.dy)
      + longint'(r.oz) * longint'(r.dz);
    babs = (b < 0) ? -b : b;
    osq = longint'(r.ox) * longint'(r.ox) + longint'(r.oy) * longint'(r.oy)
        + longint'(r.oz) * longint'(r.oz);
    rsq = radius * radius;
    p = 128'(babs) * 128'(babs) + (128'(rsq) << (2 * rsi_pkg::FRAC_BITS_DEF));
    q = 128'(osq) << (2 * rsi_pkg::FRAC_BITS_DEF);
    e.hit = 1'b0;
    t = 0;
    if (p >= q) begin
      disc = p - q;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        cw = 128'(cand);
        if (disc >= cw * cw) root = cand;
      end
      t1 = -b - longint'(root);
      t2 = -b + longint'(root);
      if (r.op == rsi_pkg::OP_RAY) begin
        if (t1 >= 0) begin e.hit = 1'b1; t = t1; end
        else if (t2 >= 0) begin e.hit = 1'b1; t = t2; end
      end else begin
        lo = longint'(margin) <<< rsi_pkg::FRAC_BITS_DEF;
        hi = (longint'(r.len) - longint'(margin)) <<< rsi_pkg::FRAC_BITS_DEF;
        if (t1 >= lo && t1 <= hi) begin e.hit = 1'b1; t = t1; end
        else if (t2 >= lo && t2 <= hi) begin e.hit = 1'b1; t = t2; end
      end
    end
    dq = longint'(t) >> rsi_pkg::FRAC_BITS_DEF;
    if (!e.hit) dq = 0;
    e.distance = (dq > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dq[30:0];
    pending.push_back(e);
  endfunction

  task check_result(logic hit, logic [30:0] distance);
    hit_word_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result hit=%0b distance=%0d", hit, distance));
    end else begin
      e = pending.pop_front();
      if (hit !== e.hit)
        report($sformatf("hit %0b, expected %0b", hit, e.hit));
      if (distance !== e.distance)
        report($sformatf("distance %0d, expected %0d", distance, e.distance));
    end
  endtask
endclass

module testbench;
  import rsi_pkg::*;

  localparam int LATENCY = 58;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RADIUS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = OP_RAY;
  logic signed [31:0]   in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [17:0]   in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [30:0]          in_segment_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_hit;
  logic [30:0]          out_distance;

  intersect_board board = new();
  int  cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_request = 0;

  ray_sphere_intersect_unit DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls per word, and one long hold-off on request.
  initial begin
    int k;
    forever begin
      if (hold_request > 0) begin
        k = hold_request;
        hold_request = 0;
      end else begin
        k = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      board.check_result(out_hit, out_distance);
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val[CFG_W-1:0];
    if (idx == REG_RADIUS) board.radius = val & 64'h7FFF_FFFF;
    else board.margin = val & 64'hFFFF;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task send_ray(ray_word_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= r.op;
    in_origin_x       <= r.ox;
    in_origin_y       <= r.oy;
    in_origin_z       <= r.oz;
    in_dir_x          <= r.dx;
    in_dir_y          <= r.dy;
    in_dir_z          <= r.dz;
    in_segment_length <= r.len;
    do @(posedge clk); while (!(in_valid && in_ready));
    board.note_ray(r);
  endtask

  // Drop valid at the edge that took the last word, then wait for every result.
  task drain;
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic ray_word_t make_ray(logic op, int ox, int oy, int oz,
                                         int dx, int dy, int dz, int len);
    ray_word_t r;
    r.op = op; r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = 18'(dx); r.dy = 18'(dy); r.dz = 18'(dz); r.len = 31'(len);
    return r;
  endfunction

  function automatic ray_word_t random_ray();
    ray_word_t r;
    int sh;
    r.op = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) begin
      // Raw noise over every bit of the origin and length fields; directions span +/-1.0.
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.dx = 18'($urandom_range(0, 131072) - 65536);
      r.dy = 18'($urandom_range(0, 131072) - 65536);
      r.dz = 18'($urandom_range(0, 131072) - 65536);
      r.len = 31'($urandom);
    end else begin
      // Origins near the sphere scale so that many rays actually hit.
      sh = $urandom_range(6, 15);
      r.ox = $signed($urandom) >>> sh;
      r.oy = $signed($urandom) >>> sh;
      r.oz = $signed($urandom) >>> sh;
      case ($urandom_range(0, 2))
        0: begin
          r.dx = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536; r.dy = 0; r.dz = 0;
        end
        1: begin
          r.dx = 18'($urandom_range(0, 92682) - 46341);
          r.dy = 18'($urandom_range(0, 92682) - 46341);
          r.dz = $urandom_range(0, 1) ? 18'sd37837 : -18'sd37837;
        end
        default: begin
          r.dx = 18'($urandom_range(0, 131072) - 65536);
          r.dy = 18'($urandom_range(0, 131072) - 65536);
          r.dz = 18'($urandom_range(0, 131072) - 65536);
        end
      endcase
      r.len = 31'($urandom >> $urandom_range(sh - 4, 31));
    end
    return r;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset radius of 1.0 and margin of about 0.01.
    send_ray(make_ray(OP_RAY, -5 * 65536, 0, 0, 65536, 0, 0, 0));       // hit ahead
    send_ray(make_ray(OP_RAY, 5 * 65536, 0, 0, 65536, 0, 0, 0));        // sphere behind
    send_ray(make_ray(OP_RAY, 0, 0, 0, 0, 65536, 0, 0));                // start inside
    send_ray(make_ray(OP_RAY, -5 * 65536, 65536, 0, 65536, 0, 0, 0));   // tangent
    send_ray(make_ray(OP_RAY, -5 * 65536, 2 * 65536, 0, 65536, 0, 0, 0)); // miss
    send_ray(make_ray(OP_SEGMENT, -5 * 65536, 0, 0, 65536, 0, 0, 10 * 65536));
    send_ray(make_ray(OP_SEGMENT, -5 * 65536, 0, 0, 65536, 0, 0, 3 * 65536));
    send_ray(make_ray(OP_SEGMENT, -5 * 65536, 0, 0, 65536, 0, 0, 4 * 65536));
    send_ray(make_ray(OP_SEGMENT, 0, 0, 0, 0, 0, -65536, 1000));        // short segment
    send_ray(make_ray(OP_SEGMENT, 0, 0, 0, 0, 0, 65536, 0));
    send_ray(make_ray(OP_SEGMENT, 0, 0, 0, 0, 0, 65536, 31'h7FFF_FFFF));
    send_ray(make_ray(OP_RAY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      65536, 65536, 65536, 0));
    send_ray(make_ray(OP_RAY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      -65536, -65536, -65536, 31'h7FFF_FFFF));
    send_ray(make_ray(OP_RAY, 32'h8000_0000, 0, 32'h7FFF_FFFF, -65536, 0, 65536, 0));
    send_ray(make_ray(OP_RAY, -3 * 65536, 0, 0, 20000, 0, 0, 0));      // non-unit direction
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(REG_RADIUS, 0); write_reg(REG_MARGIN, 0); end
        1: begin write_reg(REG_RADIUS, 31'h7FFF_FFFF); write_reg(REG_MARGIN, 16'hFFFF); end
        2: begin
          write_reg(REG_RADIUS, $urandom_range(1 << 16, 1 << 24));
          write_reg(REG_MARGIN, $urandom_range(0, 16'hFFFF));
        end
        3: begin
          write_reg(REG_RADIUS, $urandom_range(1 << 10, 1 << 20));
          write_reg(REG_MARGIN, $urandom_range(0, 2000));
          no_idle = 1'b1;
          hold_request = 300;     // fill the pipeline until the input stalls
        end
        default: begin
          write_reg(REG_RADIUS, $urandom);
          write_reg(REG_MARGIN, $urandom_range(0, 16'hFFFF));
        end
      endcase
      for (int n = 0; n < 187; n++) begin
        if (phase == 3 && n == 120) no_idle = 1'b0;
        send_ray(random_ray());
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
